>>> rtl/core/dp2p_pkg.sv
// dp2p_pkg: shared types and constants of the depth pixel to point core.
// No dependencies; every other file of the core but dp2p_fifo imports it.
`timescale 1ns / 1ps
package dp2p_pkg;

	localparam int ROW_W   = 12;
	localparam int DEPTH_W = 16;
	localparam int MAGY_W  = 16;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 24;

	// register indices
	localparam logic [CIDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH = 3'd1;
	localparam logic [CIDX_W-1:0] REG_CENTER_COL  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_CENTER_ROW  = 3'd3;
	localparam logic [CIDX_W-1:0] REG_INV_FOCAL_X = 3'd4;
	localparam logic [CIDX_W-1:0] REG_INV_FOCAL_Y = 3'd5;

	localparam logic [12:0] RST_IMAGE_WIDTH = 13'd640;
	localparam logic [15:0] RST_CENTER_COL  = 16'd5120;
	localparam logic [15:0] RST_CENTER_ROW  = 16'd3840;
	localparam logic [23:0] RST_INV_FOCAL   = 24'd31457;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_RANGE = 1'b1;

	localparam logic [1:0] COORD_X    = 2'd0;
	localparam logic [1:0] COORD_Y    = 2'd1;
	localparam logic [1:0] COORD_Z    = 2'd2;
	localparam logic [1:0] COORD_DIST = 2'd3;

	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic        enable;
		logic [12:0] image_width;
		logic [15:0] center_col;
		logic [15:0] center_row;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
	} cfg_t;

	typedef struct packed {
		logic [15:0] depth_mm;
		logic        frame_start;
		logic        frame_end;
	} pixel_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [23:0]        point_z;
		logic [30:0]        point_dist;
		logic               point_invalid;
		logic [1:0]         range_coord;
		logic signed [31:0] range_min;
		logic signed [31:0] range_max;
		logic               range_empty;
		logic               last;
	} result_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [15:0] depth_mm;
		logic        frame_start;
		logic        frame_end;
		logic        ok;
		logic        neg_x;
		logic        neg_y;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE, B_PXA, B_PXB, B_PYA, B_PYB, B_SQX, B_SQY, B_SQZ, B_SUM,
		B_SQRT, B_UPD, B_EMIT
	} back_state_t;

endpackage

>>> rtl/core/dp2p_fifo.sv
// dp2p_fifo: small register queue between front and back.
// Generic width; no package dependency.
`timescale 1ns / 1ps
module dp2p_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         nonempty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

>>> rtl/core/dp2p_front.sv
// dp2p_front: accepts pixels, tracks column/row, forms centred offsets.
// Depends on dp2p_pkg.
`timescale 1ns / 1ps
module dp2p_front #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dp2p_pkg::cfg_t  cfg,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  dp2p_pkg::pixel_t pixel,
	input  logic            q_full,
	output logic            q_push,
	output dp2p_pkg::job_t  job,
	output logic [((($clog2(MAX_WIDTH) + 4) > 16) ? ($clog2(MAX_WIDTH) + 4) : 16)-1:0] mag_x,
	output logic [dp2p_pkg::MAGY_W-1:0] mag_y
);
	import dp2p_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int MAG_W = ((COL_W + 4) > 16) ? (COL_W + 4) : 16;

	logic [COL_W-1:0] col_q, col_use;
	logic [ROW_W-1:0] row_q, row_use;
	logic [17:0]      w_eff;
	logic [MAG_W:0]   dx;
	logic [MAGY_W:0]  dy;

	assign pixel_stall = q_full;
	assign q_push      = pixel_valid && !q_full;

	assign col_use = pixel.frame_start ? '0 : col_q;
	assign row_use = pixel.frame_start ? '0 : row_q;

	always_comb begin
		w_eff = 18'(cfg.image_width);
		if (cfg.image_width == '0)
			w_eff = 18'd1;
		else if (18'(cfg.image_width) > 18'(MAX_WIDTH))
			w_eff = 18'(MAX_WIDTH);
	end

	assign dx = (MAG_W + 1)'({col_use, 4'b0000}) - (MAG_W + 1)'(cfg.center_col);
	assign dy = (MAGY_W + 1)'({row_use, 4'b0000}) - (MAGY_W + 1)'(cfg.center_row);

	always_comb begin
		job.depth_mm    = pixel.depth_mm;
		job.frame_start = pixel.frame_start;
		job.frame_end   = pixel.frame_end;
		job.ok          = cfg.enable && (pixel.depth_mm != '0);
		job.neg_x       = dx[MAG_W];
		job.neg_y       = dy[MAGY_W];
		mag_x = dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
		mag_y = dy[MAGY_W] ? MAGY_W'(-dy) : dy[MAGY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if ((18'(col_use) + 18'd1) >= w_eff) begin
				col_q <= '0;
				row_q <= row_use + 1'b1;
			end else begin
				col_q <= col_use + 1'b1;
				row_q <= row_use;
			end
		end
	end
endmodule

>>> rtl/core/dp2p_back.sv
// dp2p_back: projection, distance, frame ranges and result beats.
// Depends on dp2p_pkg; one shared multiplier and a bit-pair square root.
`timescale 1ns / 1ps
module dp2p_back #(
	parameter int MAG_W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp2p_pkg::cfg_t       cfg,
	input  logic                 q_nonempty,
	output logic                 q_pop,
	input  dp2p_pkg::job_t       q_job,
	input  logic [MAG_W-1:0]     q_mag_x,
	input  logic [dp2p_pkg::MAGY_W-1:0] q_mag_y,
	output logic                 result_valid,
	input  logic                 result_stall,
	output dp2p_pkg::result_t    result
);
	import dp2p_pkg::*;

	localparam int MA_W = ((MAG_W + 16) > 32) ? (MAG_W + 16) : 32;
	localparam int MP_W = MA_W + 32;
	localparam int P2   = MAG_W + 40;
	localparam int QW   = P2 - 19;

	back_state_t state_q, state_d;

	job_t               job_q;
	logic [MAG_W-1:0]   mag_x_q;
	logic [MAGY_W-1:0]  mag_y_q;
	logic [MP_W-1:0]    prod_q;
	logic signed [31:0] x_q, y_q, dist_q;
	logic               sat_q;
	logic [63:0]        acc_q, res_q, bit_q;
	logic [4:0]         cnt_q;
	logic [2:0]         beat_q;
	logic signed [31:0] min_q [4];
	logic signed [31:0] max_q [4];

	logic [MA_W-1:0]    mul_a;
	logic [31:0]        mul_b;
	logic [MP_W-1:0]    mul_p;
	logic [31:0]        abs_x, abs_y;
	logic               rnd_neg, rnd_sat;
	logic [QW-1:0]      rnd_q;
	logic signed [31:0] rnd_v;
	logic [63:0]        trial;
	logic signed [31:0] z_s, dist_c;
	logic signed [31:0] val [4];
	logic               out_free, beat_load, beat_last;
	logic [1:0]         rc;
	result_t            beat;

	assign abs_x = x_q[31] ? 32'(-x_q) : 32'(x_q);
	assign abs_y = y_q[31] ? 32'(-y_q) : 32'(y_q);
	assign z_s   = 32'({job_q.depth_mm, 8'h00});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_PXA: begin mul_a = MA_W'(mag_x_q); mul_b = 32'(job_q.depth_mm); end
			B_PXB: begin mul_a = MA_W'(prod_q[MAG_W+15:0]); mul_b = 32'(cfg.inv_focal_x); end
			B_PYA: begin mul_a = MA_W'(mag_y_q); mul_b = 32'(job_q.depth_mm); end
			B_PYB: begin mul_a = MA_W'(prod_q[31:0]); mul_b = 32'(cfg.inv_focal_y); end
			B_SQX: begin mul_a = MA_W'(abs_x); mul_b = abs_x; end
			B_SQY: begin mul_a = MA_W'(abs_y); mul_b = abs_y; end
			B_SQZ: begin mul_a = MA_W'(z_s); mul_b = z_s; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end
	assign mul_p = mul_a * MP_W'(mul_b);

	// round Q.28 to Q.8, ties away from zero, then saturate to int32
	assign rnd_neg = (state_q == B_PYA) ? job_q.neg_x : job_q.neg_y;
	always_comb begin
		rnd_q   = QW'(((P2 + 1)'(prod_q[P2-1:0]) + (P2 + 1)'(20'h80000)) >> 20);
		rnd_sat = 1'b0;
		if (rnd_neg) begin
			if (rnd_q > QW'(64'h8000_0000)) begin
				rnd_sat = 1'b1;
				rnd_v   = S32_MIN;
			end else begin
				rnd_v = -$signed(rnd_q[31:0]);
			end
		end else if (rnd_q > QW'(64'h7fff_ffff)) begin
			rnd_sat = 1'b1;
			rnd_v   = S32_MAX;
		end else begin
			rnd_v = $signed(rnd_q[31:0]);
		end
	end

	assign trial = res_q + bit_q;

	always_comb begin
		if (sat_q || (res_q[63:31] != '0))
			dist_c = S32_MAX;
		else
			dist_c = $signed({1'b0, res_q[30:0]});
	end

	assign val[0] = x_q;
	assign val[1] = y_q;
	assign val[2] = z_s;
	assign val[3] = dist_c;

	// result beat: beat 0 is the point, beats 1..4 the ranges
	assign rc = 2'(beat_q - 3'd1);
	always_comb begin
		beat = '0;
		if (beat_q == 3'd0) begin
			beat.kind          = KIND_POINT;
			beat.point_invalid = !job_q.ok;
			if (job_q.ok) begin
				beat.point_x    = x_q;
				beat.point_y    = y_q;
				beat.point_z    = {job_q.depth_mm, 8'h00};
				beat.point_dist = dist_q[30:0];
			end
		end else begin
			beat.kind        = KIND_RANGE;
			beat.range_coord = rc;
			if (min_q[rc] > max_q[rc]) begin
				beat.range_empty = 1'b1;
			end else begin
				beat.range_min = min_q[rc];
				beat.range_max = max_q[rc];
			end
		end
		beat.last = beat_last;
	end
	assign beat_last = ((beat_q == 3'd0) && !job_q.frame_end) || (beat_q == 3'd4);
	assign out_free  = !result_valid || !result_stall;
	assign beat_load = (state_q == B_EMIT) && out_free;
	assign q_pop     = (state_q == B_IDLE) && q_nonempty;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (q_nonempty) state_d = q_job.ok ? B_PXA : B_EMIT;
			B_PXA:   state_d = B_PXB;
			B_PXB:   state_d = B_PYA;
			B_PYA:   state_d = B_PYB;
			B_PYB:   state_d = B_SQX;
			B_SQX:   state_d = B_SQY;
			B_SQY:   state_d = B_SQZ;
			B_SQZ:   state_d = B_SUM;
			B_SUM:   state_d = B_SQRT;
			B_SQRT:  if (cnt_q == 5'd31) state_d = B_UPD;
			B_UPD:   state_d = B_EMIT;
			B_EMIT:  if (beat_load && beat_last) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				job_q   <= q_job;
				mag_x_q <= q_mag_x;
				mag_y_q <= q_mag_y;
				sat_q   <= 1'b0;
			end
			B_PXA, B_PXB, B_PYB: prod_q <= mul_p;
			B_PYA: begin
				prod_q <= mul_p;
				x_q    <= rnd_v;
				sat_q  <= rnd_sat;
			end
			B_SQX: begin
				prod_q <= mul_p;
				y_q    <= rnd_v;
				sat_q  <= sat_q | rnd_sat;
			end
			B_SQY: begin
				prod_q <= mul_p;
				acc_q  <= prod_q[63:0];
			end
			B_SQZ: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + prod_q[63:0];
			end
			B_SUM: begin
				acc_q <= acc_q + prod_q[63:0];
				res_q <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
				cnt_q <= '0;
			end
			B_SQRT: begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + 5'd1;
			end
			B_UPD: dist_q <= dist_c;
			default: ;
		endcase
	end

	// frame ranges, cleared on the first pixel of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				min_q[i] <= S32_MAX;
				max_q[i] <= S32_MIN;
			end
		end else if (q_pop && q_job.frame_start) begin
			for (int i = 0; i < 4; i++) begin
				min_q[i] <= S32_MAX;
				max_q[i] <= S32_MIN;
			end
		end else if (state_q == B_UPD) begin
			for (int i = 0; i < 4; i++) begin
				if (val[i] < min_q[i]) min_q[i] <= val[i];
				if (val[i] > max_q[i]) max_q[i] <= val[i];
			end
		end
	end

	// beat counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (q_pop)
				beat_q <= '0;
			else if (beat_load)
				beat_q <= beat_q + 3'd1;
			if (beat_load)
				result_valid <= 1'b1;
			else if (!result_stall)
				result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat_load)
			result <= beat;
	end
endmodule

>>> rtl/core/depth_pixel_to_point_core.sv
// depth_pixel_to_point_core: top level of the depth pixel to point core.
// Depends on dp2p_pkg, dp2p_front, dp2p_fifo and dp2p_back.
//
// Usage
//  - pixel channel (pixel_valid / pixel_stall / pixel): one raster depth pixel per
//    beat. frame_start clears column, row and the frame ranges; frame_end asks for
//    the four range beats after the point.
//  - result channel (result_valid / result_stall / result): one point beat per
//    pixel, followed by four range beats (x, y, z, distance) on frame end; last
//    marks the final beat of a pixel.
//  - cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data): register writes,
//    always ready; only to be written with the core idle.
//  - Path: a valid point goes from acceptance to its point beat through two
//    shared-multiplier passes per axis, three squares, then a 32-step square
//    root at one result bit per cycle. An invalid point (zero depth or disabled)
//    goes from the queue straight to its point beat.
//  - Pacing: the back end pops a new pixel only when idle, after the last beat
//    of the previous pixel, so it never works on two pixels at once.
//  - The two-entry queue buffers pixels ahead of the back end, so pixel_stall
//    rises only when that queue is full.
//  - Reset (arst_n low) empties the queue, clears the counters and ranges and
//    loads the register defaults; enable resets to 0.
//  - A stalled result beat holds; the back end waits on it and the queue fills.
`timescale 1ns / 1ps
module depth_pixel_to_point_core #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pixel_valid,
	output logic                         pixel_stall,
	input  dp2p_pkg::pixel_t             pixel,
	output logic                         result_valid,
	input  logic                         result_stall,
	output dp2p_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dp2p_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [dp2p_pkg::CDATA_W-1:0] cfg_data
);
	import dp2p_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int MAG_W = ((COL_W + 4) > 16) ? (COL_W + 4) : 16;
	localparam int Q_W   = $bits(job_t) + MAG_W + MAGY_W;

	cfg_t              cfg_q;
	logic              q_push, q_pop, q_full, q_nonempty;
	job_t              f_job, b_job;
	logic [MAG_W-1:0]  f_mag_x, b_mag_x;
	logic [MAGY_W-1:0] f_mag_y, b_mag_y;
	logic [Q_W-1:0]    q_rdata;

	// register file: writes take effect at once, unknown indices are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable      <= 1'b0;
			cfg_q.image_width <= RST_IMAGE_WIDTH;
			cfg_q.center_col  <= RST_CENTER_COL;
			cfg_q.center_row  <= RST_CENTER_ROW;
			cfg_q.inv_focal_x <= RST_INV_FOCAL;
			cfg_q.inv_focal_y <= RST_INV_FOCAL;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:      cfg_q.enable      <= cfg_data[0];
				REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data[12:0];
				REG_CENTER_COL:  cfg_q.center_col  <= cfg_data[15:0];
				REG_CENTER_ROW:  cfg_q.center_row  <= cfg_data[15:0];
				REG_INV_FOCAL_X: cfg_q.inv_focal_x <= cfg_data;
				REG_INV_FOCAL_Y: cfg_q.inv_focal_y <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: counting and offset classification
	dp2p_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.q_full      (q_full),
		.q_push      (q_push),
		.job         (f_job),
		.mag_x       (f_mag_x),
		.mag_y       (f_mag_y)
	);

	// two-entry queue decouples the pixel side from the arithmetic
	dp2p_fifo #(.W(Q_W), .DEPTH(2)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    ({f_job, f_mag_x, f_mag_y}),
		.pop      (q_pop),
		.rdata    (q_rdata),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	assign {b_job, b_mag_x, b_mag_y} = q_rdata;

	// back: projection, distance, ranges, beat sequencing
	dp2p_back #(.MAG_W(MAG_W)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_nonempty   (q_nonempty),
		.q_pop        (q_pop),
		.q_job        (b_job),
		.q_mag_x      (b_mag_x),
		.q_mag_y      (b_mag_y),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);
endmodule

>>> rtl/core/dp2p_checker.sv
// dp2p_checker: port-level checks of the depth pixel to point core.
// Depends on dp2p_pkg; bound to depth_pixel_to_point_core below.
`timescale 1ns / 1ps
module dp2p_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input dp2p_pkg::result_t result
);
	import dp2p_pkg::*;

	logic fire;
	assign fire = result_valid && !result_stall;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	a_range_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.kind == KIND_RANGE |-> result.last == (result.range_coord == COORD_DIST))
		else $error("range beat last flag wrong");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.kind == KIND_POINT && result.point_invalid |->
		result.point_x == '0 && result.point_y == '0 && result.point_z == '0 &&
		result.point_dist == '0)
		else $error("invalid point carries data");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		fire && result.kind == KIND_RANGE |->
		(result.range_empty && result.range_min == '0 && result.range_max == '0) ||
		(!result.range_empty && result.range_min <= result.range_max))
		else $error("range beat inconsistent");
endmodule

bind depth_pixel_to_point_core dp2p_checker u_dp2p_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> dv/depth_pixel_to_point_core_tb.sv
// depth_pixel_to_point_core_tb: self-checking bench of the depth pixel to point core.
// Depends on dp2p_pkg and the RTL of depth_pixel_to_point_core; drives pixels and
// register writes, predicts every result beat and compares it field by field.
`timescale 1ns / 1ps
module depth_pixel_to_point_core_tb;
	import dp2p_pkg::*;

	localparam int LIMIT  = 150000;  // cycles; the slowest correct run is far below
	localparam int DRAIN  = 60;      // wait after the last expected beat has been seen
	localparam int N_RAND = 250;

	logic clk, arst_n;
	logic pixel_valid, pixel_stall;
	pixel_t pixel;
	logic result_valid, result_stall;
	result_t result;
	logic cfg_valid, cfg_ready;
	logic [CIDX_W-1:0] cfg_index;
	logic [CDATA_W-1:0] cfg_data;

	depth_pixel_to_point_core DUT (
		.clk(clk), .arst_n(arst_n),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall), .pixel(pixel),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the registers and of the core's counters and frame ranges
	logic        sh_enable;
	logic [12:0] sh_width;
	logic [15:0] sh_ccol, sh_crow;
	logic [23:0] sh_ifx, sh_ify;
	logic [11:0] col_cnt, row_cnt;
	logic signed [31:0] rng_min [4];
	logic signed [31:0] rng_max [4];

	result_t pending_results [$];
	bit      literal_q [$];       // per pixel in flight: expectation typed in by hand
	result_t literal_beats [$];   // the hand-typed beats themselves

	int errors, cycles, n_pixels, n_beats, n_ranges;
	bit quiet;                    // no gaps and no stalls while set

	logic [12:0] widths [8] = '{13'd1, 13'd2, 13'd3, 13'd5, 13'd8, 13'd0, 13'd8191,
		13'd4096};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- predictor ----------------

	function automatic logic signed [31:0] project_axis(input logic [11:0] pos,
			input logic [15:0] ctr, input logic [15:0] depth, input logic [23:0] inv,
			output bit sat);
		longint d;
		logic [63:0] mag, prod, q;
		logic [31:0] t;
		sat = 1'b0;
		d = $signed({48'd0, pos, 4'd0}) - $signed({48'd0, ctr});
		mag = (d < 0) ? -d : d;
		prod = mag * {48'd0, depth} * {40'd0, inv};
		q = (prod + 64'h8_0000) >> 20;
		t = q[31:0];
		if (d < 0) begin
			if (q > 64'h8000_0000) begin
				sat = 1'b1;
				return S32_MIN;
			end
			return -t;
		end
		if (q > 64'h7fff_ffff) begin
			sat = 1'b1;
			return S32_MAX;
		end
		return t;
	endfunction

	function automatic logic [63:0] square_mag(input logic signed [31:0] v);
		longint s;
		logic [63:0] m;
		s = v;
		m = (s < 0) ? -s : s;
		return m * m;
	endfunction

	// bit-serial integer square root, floor
	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, b;
		res = '0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// works out the beats of one accepted pixel and advances the shadow state
	task automatic project_pixel(input pixel_t p, input bit literal);
		result_t r;
		result_t beats [$];
		logic signed [31:0] v [4];
		logic [63:0] dist_v;
		bit sx, sy;
		int w;
		if (p.frame_start) begin
			col_cnt = '0;
			row_cnt = '0;
			for (int i = 0; i < 4; i++) begin
				rng_min[i] = S32_MAX;
				rng_max[i] = S32_MIN;
			end
		end
		r = '0;
		r.kind = KIND_POINT;
		if (sh_enable && p.depth_mm != 0) begin
			v[0] = project_axis(col_cnt, sh_ccol, p.depth_mm, sh_ifx, sx);
			v[1] = project_axis(row_cnt, sh_crow, p.depth_mm, sh_ify, sy);
			v[2] = {8'd0, p.depth_mm, 8'd0};
			if (sx || sy) dist_v = 64'h7fff_ffff;
			else begin
				dist_v = isqrt(square_mag(v[0]) + square_mag(v[1]) + square_mag(v[2]));
				if (dist_v > 64'h7fff_ffff) dist_v = 64'h7fff_ffff;
			end
			v[3] = dist_v[31:0];
			r.point_x = v[0];
			r.point_y = v[1];
			r.point_z = v[2][23:0];
			r.point_dist = dist_v[30:0];
			for (int i = 0; i < 4; i++) begin
				if (v[i] < rng_min[i]) rng_min[i] = v[i];
				if (v[i] > rng_max[i]) rng_max[i] = v[i];
			end
		end else begin
			r.point_invalid = 1'b1;
		end
		beats.push_back(r);
		if (p.frame_end) begin
			for (int c = 0; c < 4; c++) begin
				r = '0;
				r.kind = KIND_RANGE;
				r.range_coord = c[1:0];
				if (rng_min[c] > rng_max[c]) r.range_empty = 1'b1;
				else begin
					r.range_min = rng_min[c];
					r.range_max = rng_max[c];
				end
				beats.push_back(r);
			end
		end
		beats[beats.size()-1].last = 1'b1;
		// hand-typed rows replace the computed beats
		if (literal) begin
			beats = {};
			do beats.push_back(literal_beats.pop_front());
			while (!beats[beats.size()-1].last);
		end
		foreach (beats[i]) pending_results.push_back(beats[i]);

		w = (sh_width == 0) ? 1 : (sh_width > 4096) ? 4096 : sh_width;
		if (int'(col_cnt) + 1 >= w) begin
			col_cnt = '0;
			row_cnt = row_cnt + 1'b1;
		end else begin
			col_cnt = col_cnt + 1'b1;
		end
	endtask

	// pixel acceptance: inputs sampled at the edge are the pre-edge values
	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall) begin
			n_pixels++;
			project_pixel(pixel, literal_q.pop_front());
		end
	end

	// result side: compare each accepted beat, then draw the next stall
	int hold;
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				n_beats++;
				if (result.kind == KIND_RANGE) n_ranges++;
				if (pending_results.size() == 0) begin
					$error("unexpected beat: kind %0b last %0b", result.kind, result.last);
					errors++;
				end else begin
					e = pending_results.pop_front();
					if (result.kind !== e.kind) begin
						$error("kind: expected %0b, got %0b", e.kind, result.kind); errors++;
					end
					if (result.point_x !== e.point_x) begin
						$error("point_x: expected %0d, got %0d", e.point_x, result.point_x);
						errors++;
					end
					if (result.point_y !== e.point_y) begin
						$error("point_y: expected %0d, got %0d", e.point_y, result.point_y);
						errors++;
					end
					if (result.point_z !== e.point_z) begin
						$error("point_z: expected %0d, got %0d", e.point_z, result.point_z);
						errors++;
					end
					if (result.point_dist !== e.point_dist) begin
						$error("point_dist: expected %0d, got %0d", e.point_dist,
							result.point_dist);
						errors++;
					end
					if (result.point_invalid !== e.point_invalid) begin
						$error("point_invalid: expected %0b, got %0b", e.point_invalid,
							result.point_invalid);
						errors++;
					end
					if (result.range_coord !== e.range_coord) begin
						$error("range_coord: expected %0d, got %0d", e.range_coord,
							result.range_coord);
						errors++;
					end
					if (result.range_min !== e.range_min) begin
						$error("range_min: expected %0d, got %0d", e.range_min,
							result.range_min);
						errors++;
					end
					if (result.range_max !== e.range_max) begin
						$error("range_max: expected %0d, got %0d", e.range_max,
							result.range_max);
						errors++;
					end
					if (result.range_empty !== e.range_empty) begin
						$error("range_empty: expected %0b, got %0b", e.range_empty,
							result.range_empty);
						errors++;
					end
					if (result.last !== e.last) begin
						$error("last: expected %0b, got %0b", e.last, result.last); errors++;
					end
				end
				hold = quiet ? 0 : $urandom_range(0, 4);
			end else if (hold > 0) begin
				hold--;
			end
			result_stall <= (hold != 0);
		end
	end

	// ---------------- drivers ----------------

	task automatic send_pixel(input logic [15:0] d, input bit s, input bit e,
			input bit literal);
		int gap;
		pixel_t p;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		p.depth_mm = d;
		p.frame_start = s;
		p.frame_end = e;
		literal_q.push_back(literal);
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (pixel_stall);
	endtask

	// every pixel gives at least one beat, so an empty queue plus a short drain is idle
	task automatic wait_idle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// back-to-back writes keep valid high; write_camera drops it after the last one
	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ENABLE:      sh_enable = d[0];
			REG_IMAGE_WIDTH: sh_width  = d[12:0];
			REG_CENTER_COL:  sh_ccol   = d[15:0];
			REG_CENTER_ROW:  sh_crow   = d[15:0];
			REG_INV_FOCAL_X: sh_ifx    = d;
			REG_INV_FOCAL_Y: sh_ify    = d;
			default: ;
		endcase
	endtask

	task automatic write_camera(input bit en, input logic [12:0] w, input logic [15:0] cc,
			input logic [15:0] cr, input logic [23:0] fx, input logic [23:0] fy);
		wait_idle();
		write_reg(REG_ENABLE, {23'd0, en});
		write_reg(REG_IMAGE_WIDTH, {11'd0, w});
		write_reg(REG_CENTER_COL, {8'd0, cc});
		write_reg(REG_CENTER_ROW, {8'd0, cr});
		write_reg(REG_INV_FOCAL_X, fx);
		write_reg(REG_INV_FOCAL_Y, fy);
		cfg_valid <= 1'b0;
	endtask

	// ---------------- directed table ----------------

	typedef struct {
		logic [15:0] depth;
		bit start, fin, literal;
	} pix_row_t;

	localparam int N_DIR = 20;
	pix_row_t dir_rows [N_DIR] = '{
		// after reset, disabled: invalid points and empty ranges, typed in
		'{16'd1000, 1, 0, 1}, '{16'd0, 0, 0, 1}, '{16'd65535, 0, 1, 1},
		// default camera, enabled, width 4: wrap over a small raster
		'{16'd0, 1, 0, 0}, '{16'd1, 0, 0, 0}, '{16'd65535, 0, 0, 0}, '{16'd500, 0, 0, 0},
		'{16'd1234, 0, 0, 0}, '{16'd300, 0, 1, 0},
		// frame end without a start keeps gathering
		'{16'd800, 0, 1, 0},
		// start and end on one zero pixel: empty frame
		'{16'd0, 1, 1, 1},
		// extreme camera: X on the centre column, saturated Y
		'{16'd65535, 1, 0, 0}, '{16'd65535, 0, 0, 0}, '{16'd1, 0, 0, 0},
		'{16'd40000, 0, 1, 0},
		// width 0 acts as 1
		'{16'd7, 1, 0, 0}, '{16'd9, 0, 1, 0},
		// width above the maximum acts as the maximum
		'{16'd65535, 1, 0, 0}, '{16'd2, 0, 0, 0}, '{16'd3, 0, 1, 0}
	};

	task automatic play_rows(input int from, input int upto);
		for (int i = from; i < upto; i++)
			send_pixel(dir_rows[i].depth, dir_rows[i].start, dir_rows[i].fin,
				dir_rows[i].literal);
	endtask

	// hand-typed beats: an invalid point, with four empty ranges if the frame ends
	task automatic type_invalid(input bit fin);
		result_t r;
		r = '0;
		r.kind = KIND_POINT;
		r.point_invalid = 1'b1;
		r.last = !fin;
		literal_beats.push_back(r);
		if (fin) begin
			for (int c = 0; c < 4; c++) begin
				r = '0;
				r.kind = KIND_RANGE;
				r.range_coord = c[1:0];
				r.range_empty = 1'b1;
				r.last = (c == 3);
				literal_beats.push_back(r);
			end
		end
	endtask

	function automatic logic [15:0] rand_depth();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hffff;
			2: return 16'($urandom_range(1, 15));
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [23:0] rand_focal();
		case ($urandom_range(0, 7))
			0: return 24'd1;
			1: return 24'hff_ffff;
			2: return 24'($urandom_range(1, 24'hff_ffff));
			default: return 24'($urandom_range(10000, 80000));
		endcase
	endfunction

	function automatic logic [15:0] rand_centre();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------- main sequence ----------------

	initial begin
		int w, npix, sent;
		bit s, e;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		quiet = 1'b0;
		hold = 0;
		sh_enable = 1'b0;
		sh_width = RST_IMAGE_WIDTH;
		sh_ccol = RST_CENTER_COL;
		sh_crow = RST_CENTER_ROW;
		sh_ifx = RST_INV_FOCAL;
		sh_ify = RST_INV_FOCAL;
		col_cnt = '0;
		row_cnt = '0;
		for (int i = 0; i < 4; i++) begin
			rng_min[i] = S32_MAX;
			rng_max[i] = S32_MIN;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		type_invalid(0);
		type_invalid(0);
		type_invalid(1);
		play_rows(0, 3);
		write_camera(1, 13'd4, RST_CENTER_COL, RST_CENTER_ROW, RST_INV_FOCAL, RST_INV_FOCAL);
		play_rows(3, 10);
		type_invalid(1);
		play_rows(10, 11);
		write_camera(1, 13'd1, 16'd0, 16'hffff, 24'hff_ffff, 24'hff_ffff);
		play_rows(11, 15);
		write_camera(1, 13'd0, 16'hffff, 16'd0, 24'd1, 24'd1);
		play_rows(15, 17);
		write_camera(1, 13'd8191, 16'd32000, 16'd24000, 24'd40000, 24'd40000);
		play_rows(17, 20);

		// random part: mostly whole frames, some broken ones
		sent = 0;
		while (sent < N_RAND) begin
			w = $urandom_range(0, 7);
			write_camera(($urandom_range(0, 7) != 0), widths[w], rand_centre(), rand_centre(),
				rand_focal(), rand_focal());
			for (int f = 0; f < 4; f++) begin
				quiet = ($urandom_range(0, 4) == 0);
				npix = $urandom_range(1, 12);
				for (int k = 0; k < npix; k++) begin
					s = (k == 0);
					e = (k == npix - 1);
					if ($urandom_range(0, 9) == 0) s = ~s;
					if ($urandom_range(0, 9) == 0) e = ~e;
					send_pixel(rand_depth(), s, e, 0);
					sent++;
				end
			end
		end

		// drain
		pixel_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected beats never arrived", pending_results.size());
			errors++;
		end

		$display("Covered %0d pixels giving %0d result beats (%0d range beats),",
			n_pixels, n_beats, n_ranges);
		$display("over many camera settings incl. width clamping and saturation.");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/dp2p_pkg.sv
rtl/core/dp2p_fifo.sv
rtl/core/dp2p_front.sv
rtl/core/dp2p_back.sv
rtl/core/depth_pixel_to_point_core.sv
rtl/core/dp2p_checker.sv
dv/depth_pixel_to_point_core_tb.sv
